[sv/tqws_pkg.sv]
package tqws_pkg;

    // queue geometry
    localparam int QueueDepth = 16;
    localparam int PTR_W      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CNT_W      = $clog2(QueueDepth + 1);

    // field widths
    localparam int ID_W     = 16;
    localparam int TOTAL_W  = 24;
    localparam int ENTRY_W  = ID_W + TOTAL_W;
    localparam int STATUS_W = 2;
    localparam int WEIGHT_W = 4;
    localparam int TALLY_W  = 32;
    localparam int REV_W    = 40;

    // weight after reset
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(2);

    // function codes
    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_SERVE   = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SERVED   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd3;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [CNT_W-1:0]   t_cnt;

    // wrap a queue pointer
    function automatic t_ptr next_slot(input t_ptr p);
        if (p == PTR_W'(QueueDepth - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

[sv/two_queue_weighted_scheduler.sv]
// enqueue word: accepted, result in the output register at the next edge
// serve word: the queue memory is read into a read-data register, then the result is registered
// throughput: one enqueue per cycle unless held off; a serve holds the input off until its
// word is registered; a stalled result holds the input off until the cycle it is taken
// synchronous active-low reset clears pointers, counts, run length, tally, revenue, weight
// to 2; queue memories hold no reset and are only read below the fill count
module two_queue_weighted_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tqws_pkg::WEIGHT_W-1:0] i_cfg_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic                          i_high_priority,
    input  logic [tqws_pkg::ID_W-1:0]     i_order_id,
    input  logic [tqws_pkg::TOTAL_W-1:0]  i_order_total,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tqws_pkg::STATUS_W-1:0] o_status,
    output logic [tqws_pkg::ID_W-1:0]     o_served_id,
    output logic [tqws_pkg::TOTAL_W-1:0]  o_served_total,
    output logic                          o_served_from_high,
    output logic [tqws_pkg::TALLY_W-1:0]  o_delivered_count,
    output logic [tqws_pkg::REV_W-1:0]    o_revenue
);
    import tqws_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // queue memories
    t_entry mem_hi [QueueDepth];
    t_entry mem_no [QueueDepth];
    t_entry r_hi_rdata;
    t_entry r_no_rdata;

    logic                r_state;
    logic                r_src_hi;
    logic [WEIGHT_W-1:0] r_weight;
    logic [WEIGHT_W-1:0] r_high_run;
    t_ptr                r_hi_head, r_hi_tail, r_no_head, r_no_tail;
    t_cnt                r_hi_count, r_no_count;
    logic [TALLY_W-1:0]  r_tally;
    logic [REV_W-1:0]    r_rev;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_id;
    logic [TOTAL_W-1:0]  r_total;
    logic                r_from_high;
    logic [TALLY_W-1:0]  r_out_tally;
    logic [REV_W-1:0]    r_out_rev;

    logic                slot_free;
    logic                acc;
    logic                high_turn, hi_ne, no_ne, sel_hi, sel_no;
    logic                enq_hi_we, enq_no_we, hi_full, no_full;
    logic                deq_hi, deq_no;
    logic                load_read;
    t_entry              rd_word;
    logic [TOTAL_W-1:0]  rd_total;
    logic [REV_W:0]      rev_sum;
    logic [REV_W-1:0]    n_rev;
    logic [TALLY_W-1:0]  n_tally;

    // handshake
    assign slot_free   = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != ST_IDLE) || !slot_free;
    assign acc         = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // weighted round robin choice
    assign high_turn = r_high_run < r_weight;
    assign hi_ne     = r_hi_count != '0;
    assign no_ne     = r_no_count != '0;
    assign sel_hi    = high_turn ? hi_ne : (!no_ne && hi_ne);
    assign sel_no    = high_turn ? (!hi_ne && no_ne) : no_ne;

    // enqueue and dequeue strobes
    assign hi_full   = r_hi_count == CNT_W'(QueueDepth);
    assign no_full   = r_no_count == CNT_W'(QueueDepth);
    assign enq_hi_we = acc && (i_func == FUNC_ENQUEUE) && i_high_priority && !hi_full;
    assign enq_no_we = acc && (i_func == FUNC_ENQUEUE) && !i_high_priority && !no_full;
    assign deq_hi    = acc && (i_func == FUNC_SERVE) && sel_hi;
    assign deq_no    = acc && (i_func == FUNC_SERVE) && sel_no;

    // served word and saturating totals
    assign load_read = (r_state == ST_READ) && slot_free;
    assign rd_word   = r_src_hi ? r_hi_rdata : r_no_rdata;
    assign rd_total  = rd_word[TOTAL_W-1:0];
    assign rev_sum   = {1'b0, r_rev} + (REV_W+1)'(rd_total);
    assign n_rev     = rev_sum[REV_W] ? '1 : rev_sum[REV_W-1:0];
    assign n_tally   = (r_tally == '1) ? r_tally : r_tally + TALLY_W'(1);

    // memory ports
    always_ff @(posedge i_clk) begin
        if (enq_hi_we) begin
            mem_hi[r_hi_tail] <= {i_order_id, i_order_total};
        end
        if (deq_hi) begin
            r_hi_rdata <= mem_hi[r_hi_head];
        end
        if (enq_no_we) begin
            mem_no[r_no_tail] <= {i_order_id, i_order_total};
        end
        if (deq_no) begin
            r_no_rdata <= mem_no[r_no_head];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_src_hi   <= 1'b0;
            r_weight   <= WEIGHT_RESET;
            r_high_run <= '0;
            r_hi_head  <= '0;
            r_hi_tail  <= '0;
            r_hi_count <= '0;
            r_no_head  <= '0;
            r_no_tail  <= '0;
            r_no_count <= '0;
            r_tally    <= '0;
            r_rev      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_weight <= i_cfg_data;
            end
            if (enq_hi_we) begin
                r_hi_tail  <= next_slot(r_hi_tail);
                r_hi_count <= r_hi_count + CNT_W'(1);
            end
            if (enq_no_we) begin
                r_no_tail  <= next_slot(r_no_tail);
                r_no_count <= r_no_count + CNT_W'(1);
            end
            if (deq_hi) begin
                r_hi_head  <= next_slot(r_hi_head);
                r_hi_count <= r_hi_count - CNT_W'(1);
                if (high_turn) begin
                    r_high_run <= r_high_run + WEIGHT_W'(1);
                end
            end
            if (deq_no) begin
                r_no_head  <= next_slot(r_no_head);
                r_no_count <= r_no_count - CNT_W'(1);
                if (!high_turn) begin
                    r_high_run <= '0;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (deq_hi || deq_no) begin
                        r_state  <= ST_READ;
                        r_src_hi <= deq_hi;
                    end
                end
                ST_READ: begin
                    if (load_read) begin
                        r_state <= ST_IDLE;
                        r_tally <= n_tally;
                        r_rev   <= n_rev;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_read || (acc && !(deq_hi || deq_no))) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load_read) begin
            r_status    <= STAT_SERVED;
            r_id        <= rd_word[ENTRY_W-1:TOTAL_W];
            r_total     <= rd_total;
            r_from_high <= r_src_hi;
            r_out_tally <= n_tally;
            r_out_rev   <= n_rev;
        end else if (acc && !(deq_hi || deq_no)) begin
            if (i_func == FUNC_SERVE) begin
                r_status <= STAT_EMPTY;
            end else if (enq_hi_we || enq_no_we) begin
                r_status <= STAT_ENQUEUED;
            end else begin
                r_status <= STAT_DROPPED;
            end
            r_id        <= '0;
            r_total     <= '0;
            r_from_high <= 1'b0;
            r_out_tally <= r_tally;
            r_out_rev   <= r_rev;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_status;
    assign o_served_id        = r_id;
    assign o_served_total     = r_total;
    assign o_served_from_high = r_from_high;
    assign o_delivered_count  = r_out_tally;
    assign o_revenue          = r_out_rev;

endmodule
